// ===== rtl/core/fnvd_pkg.sv =====
package fnvd_pkg;

    localparam int SOURCE_DEPTH = 1024;
    localparam int SRC_AW       = $clog2(SOURCE_DEPTH);
    localparam int TABLE_DEPTH  = 256;
    localparam int TBL_AW       = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int CORNERS      = 3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TRI  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [9:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         joint;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
        logic               mesh_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_index;
        logic               is_new;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [7:0]         joint_out;
        logic               last;
        logic               overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         j;
    } vtx_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } nrm_t;

    typedef struct packed {
        vtx_t v;
        nrm_t n;
    } entry_t;

    // token travelling down the search chain
    typedef struct packed {
        logic              tok;
        logic              hit;
        logic [TBL_AW-1:0] idx;
    } hop_t;

endpackage

// ===== rtl/core/fnvd_in_if.sv =====
interface fnvd_in_if;
    logic                valid;
    logic                ready;
    fnvd_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fnvd_out_if.sv =====
interface fnvd_out_if;
    logic                valid;
    logic                ready;
    fnvd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fnvd_src_mem.sv =====
module fnvd_src_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [fnvd_pkg::SRC_AW-1:0] waddr,
    input  fnvd_pkg::vtx_t              wdata,
    input  logic [fnvd_pkg::SRC_AW-1:0] raddr,
    output fnvd_pkg::vtx_t              rdata
);
    import fnvd_pkg::*;

    vtx_t mem [SOURCE_DEPTH];
    vtx_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fnvd_norm.sv =====
module fnvd_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fnvd_pkg::vtx_t a,
    input  fnvd_pkg::vtx_t b,
    input  fnvd_pkg::vtx_t c,
    output logic           done,
    output fnvd_pkg::nrm_t nrm
);
    import fnvd_pkg::*;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_DIFF  = 3'd1;
    localparam logic [2:0] N_CROSS = 3'd2;
    localparam logic [2:0] N_SCALE = 3'd3;
    localparam logic [2:0] N_SQ    = 3'd4;
    localparam logic [2:0] N_SQRT  = 3'd5;
    localparam logic [2:0] N_DIV   = 3'd6;
    localparam logic [2:0] N_DONE  = 3'd7;

    logic [2:0]         state_reg;
    logic [4:0]         cnt_reg;
    logic [1:0]         comp_reg;
    logic signed [16:0] u_reg [3];
    logic signed [16:0] v_reg [3];
    logic signed [33:0] prod_reg;
    logic signed [35:0] cr_reg [3];
    logic [29:0]        mag_reg [3];
    logic               neg_reg [3];
    logic [59:0]        sq_reg;
    logic [61:0]        sum_reg;
    logic [61:0]        res_reg;
    logic [61:0]        bit_reg;
    logic [45:0]        num_reg;
    logic [15:0]        q_reg;
    logic signed [15:0] nout_reg [3];

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic [2:0]         acc_j;
    logic [35:0]        magf [3];
    logic [35:0]        mx;
    logic [2:0]         sh;
    logic [29:0]        sq_a;
    logic [59:0]        sq_p;
    logic [61:0]        rb;
    logic [30:0]        len;
    logic [3:0]         qi;
    logic [47:0]        dsh;
    logic [29:0]        mag_sel;
    logic               neg_sel;
    logic [15:0]        qc;

    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    begin mul_a = u_reg[1]; mul_b = v_reg[2]; end
            3'd1:    begin mul_a = u_reg[2]; mul_b = v_reg[1]; end
            3'd2:    begin mul_a = u_reg[2]; mul_b = v_reg[0]; end
            3'd3:    begin mul_a = u_reg[0]; mul_b = v_reg[2]; end
            3'd4:    begin mul_a = u_reg[0]; mul_b = v_reg[1]; end
            3'd5:    begin mul_a = u_reg[1]; mul_b = v_reg[0]; end
            default: begin mul_a = '0;       mul_b = '0;       end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign acc_j = cnt_reg[2:0] - 3'd1;

    // magnitudes and the scale that brings the largest below 2^30
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            magf[i] = cr_reg[i][35] ? 36'(-cr_reg[i]) : 36'(cr_reg[i]);
        end
        mx = magf[0];
        if (magf[1] > mx)
        begin
            mx = magf[1];
        end
        if (magf[2] > mx)
        begin
            mx = magf[2];
        end
        sh = 3'd6;
        for (int k = 6; k >= 0; k--)
        begin
            if ((mx >> k) < 36'h0_4000_0000)
            begin
                sh = 3'(k);
            end
        end
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_a = mag_reg[0];
            2'd1:    sq_a = mag_reg[1];
            2'd2:    sq_a = mag_reg[2];
            default: sq_a = '0;
        endcase
    end

    assign sq_p = sq_a * sq_a;
    assign rb   = res_reg + bit_reg;
    assign len  = res_reg[30:0];
    assign qi   = 4'(5'd16 - cnt_reg);
    assign dsh  = 48'({len, 1'b0}) << qi;

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin mag_sel = mag_reg[0]; neg_sel = neg_reg[0]; end
            2'd1:    begin mag_sel = mag_reg[1]; neg_sel = neg_reg[1]; end
            default: begin mag_sel = mag_reg[2]; neg_sel = neg_reg[2]; end
        endcase
    end

    assign qc = (q_reg > 16'd16384) ? 16'd16384 : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= N_DIFF;
                    end
                end
                N_DIFF:
                begin
                    cnt_reg   <= '0;
                    state_reg <= N_CROSS;
                end
                N_CROSS:
                begin
                    if (cnt_reg == 5'd6)
                    begin
                        state_reg <= N_SCALE;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                N_SCALE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (mx == '0) ? N_DONE : N_SQ;
                end
                N_SQ:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd30)
                    begin
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                        state_reg <= N_DIV;
                    end
                end
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd17)
                    begin
                        cnt_reg  <= '0;
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= N_DONE;
                        end
                    end
                end
                N_DONE:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_DIFF:
            begin
                u_reg[0] <= 17'(c.x) - 17'(a.x);
                u_reg[1] <= 17'(c.y) - 17'(a.y);
                u_reg[2] <= 17'(c.z) - 17'(a.z);
                v_reg[0] <= 17'(b.x) - 17'(a.x);
                v_reg[1] <= 17'(b.y) - 17'(a.y);
                v_reg[2] <= 17'(b.z) - 17'(a.z);
            end
            N_CROSS:
            begin
                prod_reg <= mul_p;
                if (cnt_reg != 5'd0)
                begin
                    if (!acc_j[0])
                    begin
                        cr_reg[acc_j[2:1]] <= 36'(prod_reg);
                    end
                    else
                    begin
                        cr_reg[acc_j[2:1]] <= cr_reg[acc_j[2:1]] - 36'(prod_reg);
                    end
                end
            end
            N_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i]  <= 30'(magf[i] >> sh);
                    neg_reg[i]  <= cr_reg[i][35];
                    nout_reg[i] <= '0;
                end
                sum_reg <= '0;
            end
            N_SQ:
            begin
                sq_reg <= sq_p;
                if (cnt_reg != 5'd0)
                begin
                    sum_reg <= sum_reg + 62'(sq_reg);
                end
                res_reg <= '0;
                bit_reg <= 62'(1) << 60;
            end
            N_SQRT:
            begin
                if (sum_reg >= rb)
                begin
                    sum_reg <= sum_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    num_reg <= 46'({mag_sel, 15'b0}) + 46'(len);
                    q_reg   <= '0;
                end
                else if (cnt_reg == 5'd17)
                begin
                    nout_reg[comp_reg] <= neg_sel ? -$signed(qc) : $signed(qc);
                end
                else if (48'(num_reg) >= dsh)
                begin
                    num_reg   <= 46'(48'(num_reg) - dsh);
                    q_reg[qi] <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = (state_reg == N_DONE);
    assign nrm.x = nout_reg[0];
    assign nrm.y = nout_reg[1];
    assign nrm.z = nout_reg[2];

endmodule

// ===== rtl/core/fnvd_cell.sv =====
module fnvd_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fnvd_pkg::TBL_AW-1:0] cell_idx,
    input  logic [fnvd_pkg::CNT_W-1:0]  count,
    input  fnvd_pkg::entry_t            key,
    input  logic                        wr_en,
    input  fnvd_pkg::hop_t              hop_in,
    output fnvd_pkg::hop_t              hop_out
);
    import fnvd_pkg::*;

    entry_t entry_reg;
    hop_t   hop_reg;
    hop_t   hop_next;
    logic   valid;
    logic   match;

    assign valid = CNT_W'(cell_idx) < count;
    assign match = valid && (entry_reg == key);

    always_comb
    begin
        hop_next.tok = hop_in.tok;
        hop_next.hit = hop_in.hit | match;
        hop_next.idx = hop_in.hit ? hop_in.idx : cell_idx;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (CNT_W'(cell_idx) == count))
        begin
            entry_reg <= key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg <= '0;
        end
        else
        begin
            hop_reg <= hop_next;
        end
    end

    assign hop_out = hop_reg;

endmodule

// ===== rtl/core/flat_normal_vertex_dedup_core.sv =====
// Channel | Dir | Transfer carries
// --------+-----+-----------------------------------------------------------
// in_ch   | in  | load (func 0: slot, position, joint) or triangle (func 1)
// out_ch  | out | one result per triangle corner, three per triangle
//
// A load is taken while idle and yields nothing. A triangle goes through
// source reads, the normal (cross products, root, three divisions) and,
// for each corner, the search walk down the cell chain, one cell per cycle.
// A stalled output holds the block. Reset clears the table fill count;
// table and source contents are not cleared.
module flat_normal_vertex_dedup_core (
    input  logic        clk,
    input  logic        rst_n,
    fnvd_in_if.sink     in_ch,
    fnvd_out_if.source  out_ch
);
    import fnvd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]       state_reg;
    logic [1:0]       rd_cnt_reg;
    logic [1:0]       m_reg;
    logic [CNT_W-1:0] count_reg;
    logic             mesh_end_reg;
    logic [9:0]       corner_reg [3];
    logic             zero_reg [3];
    vtx_t             vtx_reg [3];
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic             in_fire;
    logic             out_fire;
    logic             src_we;
    vtx_t             src_wdata;
    logic [9:0]       rd_slot;
    vtx_t             src_rdata;
    logic             norm_start;
    logic             norm_done;
    nrm_t             norm;
    vtx_t             cur_vtx;
    entry_t           key;
    hop_t             hop [TABLE_DEPTH+1];
    hop_t             chain_end;
    logic             tbl_room;
    logic             tbl_wr;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    // loads go straight into the source store; out-of-range slots are dropped
    assign src_we      = in_fire && (in_ch.data.func == FUNC_LOAD)
                         && (32'(in_ch.data.slot) < SOURCE_DEPTH);
    assign src_wdata.x = in_ch.data.pos_x;
    assign src_wdata.y = in_ch.data.pos_y;
    assign src_wdata.z = in_ch.data.pos_z;
    assign src_wdata.j = in_ch.data.joint;

    always_comb
    begin
        case (rd_cnt_reg)
            2'd0:    rd_slot = corner_reg[0];
            2'd1:    rd_slot = corner_reg[1];
            default: rd_slot = corner_reg[2];
        endcase
    end

    fnvd_src_mem u_src_mem (
        .clk   (clk),
        .we    (src_we),
        .waddr (SRC_AW'(in_ch.data.slot)),
        .wdata (src_wdata),
        .raddr (SRC_AW'(rd_slot)),
        .rdata (src_rdata)
    );

    // normal unit starts once the third corner has been captured
    assign norm_start = (state_reg == S_READ) && (rd_cnt_reg == 2'd3);

    fnvd_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .a     (vtx_reg[0]),
        .b     (vtx_reg[1]),
        .c     (vtx_reg[2]),
        .done  (norm_done),
        .nrm   (norm)
    );

    always_comb
    begin
        case (m_reg)
            2'd0:    cur_vtx = vtx_reg[0];
            2'd1:    cur_vtx = vtx_reg[1];
            default: cur_vtx = vtx_reg[2];
        endcase
    end

    assign key.v = cur_vtx;
    assign key.n = norm;

    // search chain: one token enters at cell 0 and picks up the match index
    assign hop[0].tok = (state_reg == S_SRCH);
    assign hop[0].hit = 1'b0;
    assign hop[0].idx = '0;

    assign tbl_room  = count_reg < CNT_W'(TABLE_DEPTH);
    assign chain_end = hop[TABLE_DEPTH];
    assign tbl_wr    = (state_reg == S_WAIT) && chain_end.tok && !chain_end.hit && tbl_room;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        fnvd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (TBL_AW'(i)),
            .count    (count_reg),
            .key      (key),
            .wr_en    (tbl_wr),
            .hop_in   (hop[i]),
            .hop_out  (hop[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            m_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (in_ch.data.func == FUNC_TRI))
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                    if (rd_cnt_reg == 2'd3)
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        m_reg     <= '0;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (chain_end.tok)
                    begin
                        if (tbl_wr)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        if (m_reg == 2'(CORNERS - 1))
                        begin
                            if (mesh_end_reg)
                            begin
                                count_reg <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            m_reg     <= m_reg + 2'd1;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            corner_reg[0] <= in_ch.data.corner_a;
            corner_reg[1] <= in_ch.data.corner_b;
            corner_reg[2] <= in_ch.data.corner_c;
            zero_reg[0]   <= !(32'(in_ch.data.corner_a) < SOURCE_DEPTH);
            zero_reg[1]   <= !(32'(in_ch.data.corner_b) < SOURCE_DEPTH);
            zero_reg[2]   <= !(32'(in_ch.data.corner_c) < SOURCE_DEPTH);
            mesh_end_reg  <= in_ch.data.mesh_end;
        end
        // read data arrives in the cycle after its address
        if ((state_reg == S_READ) && (rd_cnt_reg != 2'd0))
        begin
            vtx_reg[rd_cnt_reg - 2'd1] <= zero_reg[rd_cnt_reg - 2'd1] ? '0 : src_rdata;
        end
        if ((state_reg == S_WAIT) && chain_end.tok)
        begin
            out_data_reg.is_new    <= tbl_wr;
            out_data_reg.overflow  <= !chain_end.hit && !tbl_room;
            if (chain_end.hit)
            begin
                out_data_reg.out_index <= 8'(chain_end.idx);
            end
            else if (tbl_room)
            begin
                out_data_reg.out_index <= 8'(count_reg);
            end
            else
            begin
                out_data_reg.out_index <= '0;
            end
            out_data_reg.new_x     <= cur_vtx.x;
            out_data_reg.new_y     <= cur_vtx.y;
            out_data_reg.new_z     <= cur_vtx.z;
            out_data_reg.joint_out <= cur_vtx.j;
            out_data_reg.norm_x    <= norm.x;
            out_data_reg.norm_y    <= norm.y;
            out_data_reg.norm_z    <= norm.z;
            out_data_reg.last      <= (m_reg == 2'(CORNERS - 1));
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

// ===== rtl/core/fnvd_checker.sv =====
module fnvd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input fnvd_pkg::out_item_t out_data
);
    import fnvd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no new item while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> !out_data.is_new && out_data.out_index == 8'd0)
        else $error("overflow result carries an index");

    a_norm_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.norm_x >= -16'sd16384 && out_data.norm_x <= 16'sd16384
            && out_data.norm_y >= -16'sd16384 && out_data.norm_y <= 16'sd16384
            && out_data.norm_z >= -16'sd16384 && out_data.norm_z <= 16'sd16384)
        else $error("normal out of range");

endmodule

bind flat_normal_vertex_dedup_core fnvd_checker u_fnvd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// ===== bench/testbench.sv =====
module testbench;
    import fnvd_pkg::*;

    // Run length and pacing
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_CYCLES  = 4000;   // long receiver hold-off, several triangles deep
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_PCT     = 29;

    logic clk;
    logic rst_n;

    fnvd_in_if  in_ch ();
    fnvd_out_if out_ch ();

    flat_normal_vertex_dedup_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the block's state
    vtx_t        src_mem [SOURCE_DEPTH];
    bit          src_loaded [SOURCE_DEPTH];
    entry_t      weld_table [TABLE_DEPTH];
    int unsigned weld_count;

    out_item_t   corner_queue [$];   // expected corner transfers, oldest first
    int          loaded_slots [$];   // slots written so far, newest last

    // Bookkeeping
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned corner_count;
    int unsigned load_count;
    int unsigned tri_count;
    int unsigned overflow_count;
    int unsigned reuse_count;
    int unsigned degenerate_count;
    bit          quiet_window;       // both sides run without idling
    bit          hold_request;
    bit          hold_done;

    // Directed stimulus rows: typed normal only where it is obvious
    typedef struct {
        in_item_t it;
        bit       typed;
        nrm_t     n;
    } stim_row_t;

    stim_row_t directed [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d corners still expected",
                     cycle_count, corner_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Face normal cross(C-A, B-A), scaled to Q1.14, round half away from zero
    function automatic nrm_t face_normal(vtx_t a, vtx_t b, vtx_t c);
        longint          ux, uy, uz, vx, vy, vz;
        longint          cr [3];
        longint unsigned mag [3];
        longint unsigned mx, sum, len, q;
        int              sh;
        logic signed [15:0] comp [3];
        nrm_t            n;
        ux = longint'(c.x) - longint'(a.x);
        uy = longint'(c.y) - longint'(a.y);
        uz = longint'(c.z) - longint'(a.z);
        vx = longint'(b.x) - longint'(a.x);
        vy = longint'(b.y) - longint'(a.y);
        vz = longint'(b.z) - longint'(a.z);
        cr[0] = uy * vz - uz * vy;
        cr[1] = uz * vx - ux * vz;
        cr[2] = ux * vy - uy * vx;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        n = '0;
        if (mx == 0)
            return n;
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> sh;
            sum    = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (64'd32768 * mag[i] + len) / (2 * len);
            if (q > 16384)
                q = 16384;
            comp[i] = (cr[i] < 0) ? -16'(q) : 16'(q);
        end
        n.x = comp[0];
        n.y = comp[1];
        n.z = comp[2];
        return n;
    endfunction

    // Applies one accepted item to the shadow state and queues its corners
    task automatic weld_item(in_item_t it, bit typed, nrm_t typed_n);
        vtx_t      cv [3];
        nrm_t      nv;
        out_item_t r;
        bit        found;
        if (it.func == FUNC_LOAD)
        begin
            src_mem[it.slot]    = '{it.pos_x, it.pos_y, it.pos_z, it.joint};
            src_loaded[it.slot] = 1'b1;
            load_count++;
            return;
        end
        tri_count++;
        cv[0] = src_mem[it.corner_a];
        cv[1] = src_mem[it.corner_b];
        cv[2] = src_mem[it.corner_c];
        nv    = typed ? typed_n : face_normal(cv[0], cv[1], cv[2]);
        if (nv == nrm_t'('0))
            degenerate_count++;
        for (int m = 0; m < CORNERS; m++)
        begin
            r     = '0;
            found = 1'b0;
            for (int e = 0; e < weld_count && !found; e++)
            begin
                if (weld_table[e].v == cv[m] && weld_table[e].n == nv)
                begin
                    found       = 1'b1;
                    r.out_index = 8'(e);
                end
            end
            if (found)
                reuse_count++;
            else if (weld_count < TABLE_DEPTH)
            begin
                r.out_index            = 8'(weld_count);
                r.is_new               = 1'b1;
                weld_table[weld_count] = '{cv[m], nv};
                weld_count++;
            end
            else
            begin
                r.overflow = 1'b1;
                overflow_count++;
            end
            r.new_x     = cv[m].x;
            r.new_y     = cv[m].y;
            r.new_z     = cv[m].z;
            r.norm_x    = nv.x;
            r.norm_y    = nv.y;
            r.norm_z    = nv.z;
            r.joint_out = cv[m].j;
            r.last      = (m == CORNERS - 1);
            corner_queue.push_back(r);
        end
        if (it.mesh_end)
            weld_count = 0;
    endtask

    // ------------------------------------------------------------------
    // Output checker: every corner transfer against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            corner_count++;
            if (corner_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected corner transfer: %p", got);
            end
            else
            begin
                want = corner_queue.pop_front();
                if (got.out_index !== want.out_index || got.is_new !== want.is_new ||
                    got.new_x !== want.new_x || got.new_y !== want.new_y ||
                    got.new_z !== want.new_z || got.norm_x !== want.norm_x ||
                    got.norm_y !== want.norm_y || got.norm_z !== want.norm_z ||
                    got.joint_out !== want.joint_out || got.last !== want.last ||
                    got.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("corner %0d mismatch at cycle %0d", corner_count,
                                 cycle_count);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                // count the hold-off here, sender keeps offering meanwhile
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                out_ch.ready <= quiet_window ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one item with random gaps; called at a falling edge
    task automatic offer(in_item_t it, bit typed, nrm_t typed_n);
        while (!quiet_window && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        weld_item(it, typed, typed_n);
        @(negedge clk);
    endtask

    function automatic in_item_t load_item(int slot, int x, int y, int z, int j);
        in_item_t it;
        it       = '0;
        it.func  = FUNC_LOAD;
        it.slot  = 10'(slot);
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.pos_z = 16'(z);
        it.joint = 8'(j);
        return it;
    endfunction

    function automatic in_item_t tri_item(int a, int b, int c, bit done);
        in_item_t it;
        it          = '0;
        it.func     = FUNC_TRI;
        it.corner_a = 10'(a);
        it.corner_b = 10'(b);
        it.corner_c = 10'(c);
        it.mesh_end = done;
        return it;
    endfunction

    // Random load: mostly small coordinates so triangles stay compact
    function automatic in_item_t random_load();
        in_item_t it;
        it       = '0;
        it.func  = FUNC_LOAD;
        it.slot  = 10'($urandom_range(1023));
        it.joint = 8'($urandom_range(255));
        if ($urandom_range(99) < 70)
        begin
            it.pos_x = 16'($urandom_range(400) - 200);
            it.pos_y = 16'($urandom_range(400) - 200);
            it.pos_z = 16'($urandom_range(400) - 200);
        end
        else
        begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
            it.pos_z = 16'($urandom);
        end
        // ignored on loads
        it.mesh_end   = $urandom_range(1);
        it.corner_a   = 10'($urandom);
        it.corner_b   = 10'($urandom);
        it.corner_c   = 10'($urandom);
        return it;
    endfunction

    function automatic int recent_slot();
        int depth;
        depth = (loaded_slots.size() < 16) ? loaded_slots.size() : 16;
        return loaded_slots[loaded_slots.size() - 1 - $urandom_range(depth - 1)];
    endfunction

    initial
    begin
        in_item_t it;
        in_item_t prev_tri;
        stim_row_t row;
        nrm_t      none;
        bit        have_prev;
        int        pick;

        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        rst_n          = 1'b0;
        quiet_window   = 1'b0;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        have_prev      = 1'b0;
        none           = '0;
        weld_count     = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        corner_count   = 0;
        load_count     = 0;
        tri_count      = 0;
        overflow_count = 0;
        reuse_count    = 0;
        degenerate_count = 0;
        for (int i = 0; i < SOURCE_DEPTH; i++)
            src_loaded[i] = 1'b0;

        // Directed rows: unit triangle both windings, degenerate, extremes,
        // joint-only difference, clear on mesh end
        directed = '{
            '{load_item(0, 0, 0, 0, 0), 1'b0, '0},
            '{load_item(1, 1, 0, 0, 0), 1'b0, '0},
            '{load_item(2, 0, 1, 0, 0), 1'b0, '0},
            '{tri_item(0, 1, 2, 1'b0), 1'b1, '{16'sd0, 16'sd0, -16'sd16384}},
            '{tri_item(0, 0, 0, 1'b0), 1'b1, '{16'sd0, 16'sd0, 16'sd0}},
            '{tri_item(2, 1, 0, 1'b0), 1'b1, '{16'sd0, 16'sd0, 16'sd16384}},
            '{tri_item(0, 1, 2, 1'b0), 1'b1, '{16'sd0, 16'sd0, -16'sd16384}},
            '{load_item(1023, 32767, 32767, 32767, 255), 1'b0, '0},
            '{load_item(1022, -32768, -32768, -32768, 0), 1'b0, '0},
            '{load_item(1021, 32767, -32768, 0, 128), 1'b0, '0},
            '{load_item(512, -32768, 32767, -1, 1), 1'b0, '0},
            '{tri_item(1021, 1022, 1023, 1'b0), 1'b0, '0},
            '{tri_item(512, 1023, 1022, 1'b0), 1'b0, '0},
            '{tri_item(1022, 1022, 1023, 1'b1), 1'b0, '0},
            '{tri_item(0, 1, 2, 1'b0), 1'b1, '{16'sd0, 16'sd0, -16'sd16384}},
            '{load_item(4, 1, 0, 0, 7), 1'b0, '0},
            '{tri_item(0, 4, 2, 1'b0), 1'b1, '{16'sd0, 16'sd0, -16'sd16384}},
            '{load_item(341, 21845, -21846, 170, 85), 1'b0, '0},
            '{tri_item(341, 1021, 512, 1'b0), 1'b0, '0},
            '{tri_item(341, 1021, 512, 1'b1), 1'b0, '0}
        };
        foreach (directed[i])
            if (directed[i].it.func == FUNC_LOAD)
                loaded_slots.push_back(directed[i].it.slot);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            offer(row.it, row.typed, row.n);
        end

        // Random part: the first half never ends the mesh so the table fills
        // and overflows; repeated triangles and shared corners give reuse.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            quiet_window = (k >= 200 && k < 260);
            if (k == 120)
                hold_request = 1'b1;
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                it = random_load();
                loaded_slots.push_back(it.slot);
            end
            else if (have_prev && pick < 50)
                it = prev_tri;
            else
            begin
                it          = tri_item(recent_slot(), recent_slot(), recent_slot(), 1'b0);
                it.slot     = 10'($urandom);
                it.pos_x    = 16'($urandom);
                it.pos_y    = 16'($urandom);
                it.pos_z    = 16'($urandom);
                it.joint    = 8'($urandom);
                // occasional degenerate corner pair
                if ($urandom_range(99) < 8)
                    it.corner_b = it.corner_a;
                prev_tri    = it;
                have_prev   = 1'b1;
            end
            if (it.func == FUNC_TRI)
                it.mesh_end = (k >= RANDOM_ITEMS / 2) && ($urandom_range(99) < 6);
            offer(it, 1'b0, none);
        end
        quiet_window = 1'b0;
        in_ch.valid <= 1'b0;

        while (corner_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d loads, %0d triangles, %0d corners checked", load_count, tri_count,
                 corner_count);
        $display("%0d corner reuses, %0d overflows, %0d flat triangles, %0d mismatches",
                 reuse_count, overflow_count, degenerate_count, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fnvd_pkg.sv
rtl/core/fnvd_in_if.sv
rtl/core/fnvd_out_if.sv
rtl/core/fnvd_src_mem.sv
rtl/core/fnvd_norm.sv
rtl/core/fnvd_cell.sv
rtl/core/flat_normal_vertex_dedup_core.sv
rtl/core/fnvd_checker.sv
bench/testbench.sv
